// File: design/hslrgb_pkg.sv
// hslrgb_pkg: payload types, fixed-point constants and the hue ramp function
// for the hsl to rgb converter. No dependencies.
package hslrgb_pkg;

    // fractions carry 16 fraction bits, hue carries 6 fraction bits
    localparam int FRAC_BITS = 16;
    localparam int HUE_FRAC_BITS = 6;
    localparam int CHANNELS = 3;

    typedef struct packed {
        logic [14:0] hue;
        logic [16:0] saturation;
        logic [16:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam logic [16:0] FRAC_ONE  = 17'd65536;
    localparam logic [16:0] FRAC_HALF = 17'd32768;
    localparam logic [31:0] ROUND_HALF = 32'd32768;

    // one unit of k is 30 degrees, 1920 hue steps
    localparam logic [15:0] HUE_PERIOD = 16'd23040;
    localparam logic signed [16:0] HUE_D  = 17'sd1920;
    localparam logic signed [16:0] HUE_3D = 17'sd5760;
    localparam logic signed [16:0] HUE_9D = 17'sd17280;

    // hue offsets of red, green and blue (n = 0, 8, 4)
    localparam logic [15:0] HUE_OFFSET [CHANNELS] = '{16'd0, 16'd15360, 16'd7680};

    // channel full scale is ONE*D = 15 * 2^23
    localparam logic signed [28:0] X_FULL = 29'sd125829120;
    localparam logic [34:0] X_ROUND = 35'd62914560;
    localparam int Q_SHIFT = 23;
    // floor(v/15) == (v*4370) >> 16 for v below 3840
    localparam logic [24:0] RECIP_15 = 25'd4370;

    function automatic logic signed [11:0] hue_ramp(input logic [14:0] hue,
                                                    input logic [15:0] offset);
        logic [15:0] sum;
        logic [15:0] k1;
        logic [15:0] k2;
        logic signed [16:0] ks;
        logic signed [16:0] up;
        logic signed [16:0] down;
        logic signed [16:0] f;
        sum = {1'b0, hue} + offset;
        k1 = (sum >= HUE_PERIOD) ? sum - HUE_PERIOD : sum;
        k2 = (k1 >= HUE_PERIOD) ? k1 - HUE_PERIOD : k1;
        ks = $signed({1'b0, k2});
        up = ks - HUE_3D;
        down = HUE_9D - ks;
        f = (up < down) ? up : down;
        if (f > HUE_D)
        begin
            f = HUE_D;
        end
        if (f < -HUE_D)
        begin
            f = -HUE_D;
        end
        return f[11:0];
    endfunction

endpackage

// File: design/hsl_to_rgb_converter.sv
// hsl_to_rgb_converter: six-stage pipeline turning hue, saturation and
// lightness into red, green and blue bytes. Depends on hslrgb_pkg.

// One transfer is accepted on every clock where start is high; busy is always
// low. Each accepted color gives one rgb result, shown for one cycle with done
// high. Results cannot be held off and must be taken when done is high. The
// six register stages are: clamp and hue ramp, the saturation multiply, the
// chroma-by-ramp multiply, the lightness combine, the scale by 255, and the
// divide by 15 with clamping.
module hsl_to_rgb_converter
    import hslrgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  hsl_t hsl,
    output logic done,
    output rgb_t rgb
);

    // stage valid bits
    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    // stage 1
    logic [16:0] s_clamp;
    logic [16:0] l_clamp;
    logic [16:0] m_full;
    logic [16:0] s1_sat_reg;
    logic [15:0] s1_m_reg;
    logic [16:0] s1_l_reg;
    logic signed [11:0] s1_fd_reg [CHANNELS];

    // stage 2
    logic [32:0] sm_prod;
    logic [31:0] s2_p_reg;
    logic [16:0] s2_l_reg;
    logic signed [11:0] s2_fd_reg [CHANNELS];

    // stage 3
    logic [31:0] a_sum;
    logic signed [16:0] a_val;
    logic signed [28:0] af_full [CHANNELS];
    logic signed [27:0] s3_af_reg [CHANNELS];
    logic [16:0] s3_l_reg;

    // stage 4
    logic [27:0] l_scaled;
    logic signed [28:0] x_val [CHANNELS];
    logic signed [28:0] s4_x_reg [CHANNELS];

    // stage 5
    logic [34:0] y_val [CHANNELS];
    logic [11:0] s5_v_reg [CHANNELS];
    logic [CHANNELS-1:0] s5_low_reg;
    logic [CHANNELS-1:0] s5_high_reg;

    // stage 6
    logic [24:0] q_val [CHANNELS];
    logic [7:0] chan [CHANNELS];
    rgb_t rgb_reg;

    assign busy = 1'b0;
    assign valid_next = {valid_reg[4:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // clamp and hue ramp
    always_comb
    begin
        s_clamp = (hsl.saturation > FRAC_ONE) ? FRAC_ONE : hsl.saturation;
        l_clamp = (hsl.lightness > FRAC_ONE) ? FRAC_ONE : hsl.lightness;
        m_full = (l_clamp > FRAC_HALF) ? FRAC_ONE - l_clamp : l_clamp;
    end

    always_ff @(posedge clk)
    begin
        s1_sat_reg <= s_clamp;
        s1_m_reg <= m_full[15:0];
        s1_l_reg <= l_clamp;
        for (int i = 0; i < CHANNELS; i++)
        begin
            s1_fd_reg[i] <= hue_ramp(hsl.hue, HUE_OFFSET[i]);
        end
    end

    // s * min(l, 1-l)
    assign sm_prod = 33'(s1_sat_reg) * 33'(s1_m_reg);

    always_ff @(posedge clk)
    begin
        s2_p_reg <= sm_prod[31:0];
        s2_l_reg <= s1_l_reg;
        s2_fd_reg <= s1_fd_reg;
    end

    // round chroma, then multiply by the ramp of each channel
    always_comb
    begin
        a_sum = s2_p_reg + ROUND_HALF;
        a_val = $signed({1'b0, a_sum[31:FRAC_BITS]});
        for (int i = 0; i < CHANNELS; i++)
        begin
            af_full[i] = a_val * s2_fd_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            s3_af_reg[i] <= af_full[i][27:0];
        end
        s3_l_reg <= s2_l_reg;
    end

    // x = l*D - a*fd, with l*1920 as l*2048 - l*128
    always_comb
    begin
        l_scaled = (28'(s3_l_reg) << 11) - (28'(s3_l_reg) << 7);
        for (int i = 0; i < CHANNELS; i++)
        begin
            x_val[i] = $signed({1'b0, l_scaled}) - $signed({s3_af_reg[i][27], s3_af_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        s4_x_reg <= x_val;
    end

    // scale by 255 and drop the power-of-two part of the full scale
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            y_val[i] = (35'(s4_x_reg[i][26:0]) << 8) - 35'(s4_x_reg[i][26:0]) + X_ROUND;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            s5_v_reg[i] <= y_val[i][34:Q_SHIFT];
            s5_low_reg[i] <= (s4_x_reg[i] <= 29'sd0);
            s5_high_reg[i] <= (s4_x_reg[i] >= X_FULL);
        end
    end

    // divide by 15 and clamp
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            q_val[i] = 25'(s5_v_reg[i]) * RECIP_15;
            if (s5_low_reg[i])
            begin
                chan[i] = 8'd0;
            end
            else if (s5_high_reg[i])
            begin
                chan[i] = 8'd255;
            end
            else
            begin
                chan[i] = q_val[i][23:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg.red <= chan[0];
        rgb_reg.green <= chan[1];
        rgb_reg.blue <= chan[2];
    end

    assign done = valid_reg[5];
    assign rgb = rgb_reg;

endmodule

// File: bench/testbench.sv
// testbench for hsl_to_rgb_converter: directed and random colors go in,
// each rgb result is checked against a fixed-point hsl to rgb predictor.
// depends on hslrgb_pkg for the payload types.
module testbench;
    import hslrgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC_UNIT = 64'd65536;
    localparam longint SECTOR = 64'd1920;          // 30 degrees in hue steps
    localparam longint FULL_SCALE = FRAC_UNIT * SECTOR;
    localparam int RANDOM_COLORS = 1550;
    localparam int PHASES = 4;
    localparam int SETTLE_CYCLES = 12;

    // holds the predicted colors in order and checks results against them
    class color_checker;
        rgb_t expected_rgb[$];
        int failures;
        int reported;

        function new();
            failures = 0;
            reported = 0;
        endfunction

        function automatic logic [7:0] channel_level(longint sector_offset, longint hue,
                                                     longint chroma, longint light);
            longint k;
            longint ramp;
            longint x;
            k = (sector_offset * SECTOR + hue) % (12 * SECTOR);
            ramp = k - 3 * SECTOR;
            if (9 * SECTOR - k < ramp)
            begin
                ramp = 9 * SECTOR - k;
            end
            if (ramp > SECTOR)
            begin
                ramp = SECTOR;
            end
            if (ramp < -SECTOR)
            begin
                ramp = -SECTOR;
            end
            x = light * SECTOR - chroma * ramp;
            if (x <= 0)
            begin
                return 8'd0;
            end
            if (x >= FULL_SCALE)
            begin
                return 8'd255;
            end
            return 8'((255 * x + FULL_SCALE / 2) / FULL_SCALE);
        endfunction

        function automatic rgb_t predict_rgb(hsl_t c);
            longint hue;
            longint sat;
            longint light;
            longint m;
            longint chroma;
            rgb_t r;
            hue = longint'(c.hue);
            sat = longint'(c.saturation);
            light = longint'(c.lightness);
            if (sat > FRAC_UNIT)
            begin
                sat = FRAC_UNIT;
            end
            if (light > FRAC_UNIT)
            begin
                light = FRAC_UNIT;
            end
            m = (light < FRAC_UNIT - light) ? light : FRAC_UNIT - light;
            chroma = (sat * m + FRAC_UNIT / 2) >>> 16;
            r.red = channel_level(0, hue, chroma, light);
            r.green = channel_level(8, hue, chroma, light);
            r.blue = channel_level(4, hue, chroma, light);
            return r;
        endfunction

        function void note_color(hsl_t c);
            expected_rgb = {expected_rgb, predict_rgb(c)};
        endfunction

        function void flag(string msg);
            failures++;
            if (reported < 10)
            begin
                reported++;
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void check_rgb(rgb_t got);
            rgb_t want;
            if (expected_rgb.size() == 0)
            begin
                flag($sformatf("result with nothing pending: r=%0d g=%0d b=%0d",
                               got.red, got.green, got.blue));
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
                flag($sformatf("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                               want.red, want.green, want.blue,
                               got.red, got.green, got.blue));
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    hsl_t hsl;
    logic done;
    rgb_t rgb;

    color_checker checker_h;

    hsl_to_rgb_converter dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .hsl(hsl),
        .done(done),
        .rgb(rgb)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[hsl_to_rgb_converter] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            checker_h.check_rgb(rgb);
        end
    end

    // hold start until the transfer is taken
    task automatic send_color(hsl_t c);
        @(negedge clk);
        start <= 1'b1;
        hsl <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        checker_h.note_color(c);
    endtask

    task automatic send_hsl(int h, int s, int l);
        hsl_t c;
        c.hue = 15'(h);
        c.saturation = 17'(s);
        c.lightness = 17'(l);
        send_color(c);
    endtask

    // idle cycles with junk on the payload
    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            hsl <= hsl_t'(49'({$urandom, $urandom}));
        end
    endtask

    task automatic drain_results();
        while (checker_h.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int pick_fraction();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return 0;
        end
        if (sel == 1)
        begin
            return 65536;
        end
        if (sel == 2)
        begin
            return $urandom_range(32760, 32776);
        end
        return $urandom_range(0, 65536);
    endfunction

    function automatic hsl_t random_color();
        hsl_t c;
        if ($urandom_range(0, 9) == 0)
        begin
            // full field range, including hue past 360 and fractions above one
            c.hue = 15'($urandom);
            c.saturation = 17'($urandom);
            c.lightness = 17'($urandom);
        end
        else
        begin
            c.hue = 15'($urandom_range(0, 23039));
            c.saturation = 17'(pick_fraction());
            c.lightness = 17'(pick_fraction());
        end
        return c;
    endfunction

    function automatic int random_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return 0;
        end
        if (sel < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (sel < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        checker_h = new();
        rst_n = 1'b0;
        start = 1'b0;
        hsl = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // primaries, sector edges and hue extremes at full saturation
        send_hsl(0, 65536, 32768);
        send_hsl(1920, 65536, 32768);
        send_hsl(5760, 65536, 32768);
        send_hsl(7680, 65536, 32768);
        send_hsl(9600, 65536, 32768);
        send_hsl(13440, 65536, 32768);
        send_hsl(15360, 65536, 32768);
        send_hsl(17280, 65536, 32768);
        send_hsl(21120, 65536, 32768);
        send_hsl(23039, 65536, 32768);
        // hue at or past 360 degrees wraps
        send_hsl(23040, 65536, 32768);
        send_hsl(32767, 65536, 32768);
        // black, white, gray
        send_hsl(0, 0, 0);
        send_hsl(0, 0, 65536);
        send_hsl(11520, 0, 32768);
        // saturation and lightness above one are clamped
        send_hsl(0, 131071, 131071);
        send_hsl(5000, 131071, 40000);
        send_hsl(5000, 40000, 131071);
        send_hsl(32767, 131071, 0);
        // near the ends and at the quarter points of the lightness range
        send_hsl(0, 65536, 65535);
        send_hsl(3000, 65535, 1);
        send_hsl(11520, 65536, 16384);
        send_hsl(19000, 65536, 49152);
        idle_cycles(1);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < RANDOM_COLORS / PHASES; i++)
            begin
                send_color(random_color());
                // first phase runs back to back
                if (p != 0)
                begin
                    idle_cycles(random_gap());
                end
            end
            // let the pipeline empty before the next phase
            idle_cycles(1);
            drain_results();
        end

        idle_cycles(1);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (checker_h.pending() != 0)
        begin
            checker_h.flag($sformatf("%0d results never arrived", checker_h.pending()));
        end
        if (checker_h.failures == 0)
        begin
            $display("[hsl_to_rgb_converter] OK");
        end
        else
        begin
            $display("[hsl_to_rgb_converter] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/hslrgb_pkg.sv
design/hsl_to_rgb_converter.sv
bench/testbench.sv
